/* sv/skse_pkg.sv */
// ----------------------------------------------------------------------------
// skse_pkg: shared types and constants of the sorted key set engine
// Holds the command and result word types, command and status codes, the
// control phase type, the cell control struct and the group status struct.
// ----------------------------------------------------------------------------
package skse_pkg;

	// Default sizing of the key store
	localparam int CAPACITY_DEF = 512;
	localparam int KEY_BITS_DEF = 64;

	// Fixed field widths of the command and result words
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 64;
	localparam int STAT_W  = 2;
	localparam int FIELD_W = 10;

	// Cells per group encoder (a power of two)
	localparam int GRP_SIZE  = 32;
	localparam int GRP_IDX_W = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] entry_count;
	} result_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_GRP,
		PH_FIN
	} phase_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic cmp_en;  // capture compare flags
		logic ins;     // open a slot at the insertion point
		logic del;     // close the slot of the removed key
	} cell_ctl_t;

	// Registered summary of one group of cells
	typedef struct packed {
		logic                 edge_hit;  // insertion point lies in this group
		logic [GRP_IDX_W-1:0] edge_idx;  // its place within the group
		logic                 eq_hit;    // a cell of this group holds the key
	} grp_stat_t;

endpackage

/* sv/skse_cell.sv */
// ----------------------------------------------------------------------------
// skse_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key, and on an insert takes the
// new key or its lower neighbor's key, on a remove its upper neighbor's key.
// ----------------------------------------------------------------------------
module skse_cell #(
	parameter int KEY_BITS = skse_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skse_pkg::cell_ctl_t ctl,
	input  logic                valid,
	input  logic [KEY_BITS-1:0] key_cmp,
	input  logic                lt_prev,
	input  logic [KEY_BITS-1:0] key_lo,
	input  logic [KEY_BITS-1:0] key_hi,
	output logic [KEY_BITS-1:0] key,
	output logic                lt,
	output logic                eq
);

	logic [KEY_BITS-1:0] key_q;
	logic                lt_q;
	logic                eq_q;

	// Capture compare flags against the broadcast key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			lt_q <= valid && (key_q < key_cmp);
			eq_q <= valid && (key_q == key_cmp);
		end
	end

	// Shift up on insert, down on remove, at and above the insertion point
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			key_q <= lt_prev ? key_cmp : key_lo;
		end else if (ctl.del && !lt_q) begin
			key_q <= key_hi;
		end
	end

	assign key = key_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

/* sv/skse_grp_enc.sv */
// ----------------------------------------------------------------------------
// skse_grp_enc: group encoder for a slice of the cell chain
// Turns the one-hot insertion edge and the match flags of one group of cells
// into a registered local index and hit flags.
// ----------------------------------------------------------------------------
module skse_grp_enc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [skse_pkg::GRP_SIZE-1:0] edge_vec,
	input  logic [skse_pkg::GRP_SIZE-1:0] eq_vec,
	output skse_pkg::grp_stat_t           stat
);

	skse_pkg::grp_stat_t stat_c;
	skse_pkg::grp_stat_t stat_q;

	// Encode the one-hot edge as an OR of the indexes
	always_comb begin
		stat_c.edge_hit = |edge_vec;
		stat_c.eq_hit   = |eq_vec;
		stat_c.edge_idx = '0;
		for (int i = 0; i < skse_pkg::GRP_SIZE; i++) begin
			if (edge_vec[i]) begin
				stat_c.edge_idx = stat_c.edge_idx | skse_pkg::GRP_IDX_W'(i);
			end
		end
	end

	// Hold the summary for the final combine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else if (en) begin
			stat_q <= stat_c;
		end
	end

	assign stat = stat_q;

endmodule

/* sv/sorted_key_set_engine_top.sv */
// ----------------------------------------------------------------------------
// sorted_key_set_engine_top: sorted set of distinct nonzero keys
// Add, remove or look up one key per command word in a chain of compare and
// shift cells that keeps the keys in ascending order.
//
//   channel   handshake            word       direction
//   command   start / busy         item       in
//   result    done (one cycle)     result     out
//
// A command word is accepted, compared in every cell, group encoded, then
// finally combined with the chain shift and result capture.
// The result is registered at the final combine and shows on result while done
// is high; start may be accepted again in that same cycle.
// Reset clears the fill count and the control phase; the key cells are not
// cleared, only cells below the fill count are ever compared.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_top #(
	parameter int CAPACITY = skse_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = skse_pkg::KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  skse_pkg::item_t   item,
	output logic              done,
	output skse_pkg::result_t result
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int GROUPS = (CAPACITY + skse_pkg::GRP_SIZE - 1) / skse_pkg::GRP_SIZE;
	localparam int PAD_W  = GROUPS * skse_pkg::GRP_SIZE;
	localparam int EXT_W  = skse_pkg::FIELD_W + CNT_W;

	skse_pkg::phase_t    phase_q, phase_d;
	skse_pkg::cell_ctl_t cell_ctl;
	logic                accept;
	logic                cmp_en;
	logic                grp_en;
	logic                fin;

	logic [skse_pkg::CMD_W-1:0] cmd_q;
	logic [KEY_BITS-1:0]        key_q;
	logic [CNT_W-1:0]           fill_q;

	logic [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [KEY_BITS-1:0] key_lo   [CAPACITY];
	logic [KEY_BITS-1:0] key_hi   [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-1:0] lt_ext;
	logic [CAPACITY-1:0] edge_vec;
	logic [PAD_W-1:0]    edge_pad;
	logic [PAD_W-1:0]    eq_pad;

	skse_pkg::grp_stat_t grp_stat [GROUPS];

	logic [CNT_W-1:0] pos_grp;
	logic [CNT_W-1:0] pos_c;
	logic             any_edge;
	logic             hit_c;

	logic                        do_ins;
	logic                        do_del;
	logic [skse_pkg::STAT_W-1:0] status_c;
	logic [CNT_W-1:0]            pos_out;
	logic [CNT_W-1:0]            fill_d;
	logic [EXT_W-1:0]            pos_ext;
	logic [EXT_W-1:0]            fill_ext;

	skse_pkg::result_t result_q;
	logic              done_q;

	assign accept = start && !busy;

	// Advance the control phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			skse_pkg::PH_IDLE: if (accept) phase_d = skse_pkg::PH_CMP;
			skse_pkg::PH_CMP:  phase_d = skse_pkg::PH_GRP;
			skse_pkg::PH_GRP:  phase_d = skse_pkg::PH_FIN;
			skse_pkg::PH_FIN:  phase_d = skse_pkg::PH_IDLE;
			default:           phase_d = skse_pkg::PH_IDLE;
		endcase
	end

	// Decode phase outputs
	always_comb begin
		busy   = 1'b1;
		cmp_en = 1'b0;
		grp_en = 1'b0;
		fin    = 1'b0;
		case (phase_q)
			skse_pkg::PH_IDLE: busy = 1'b0;
			skse_pkg::PH_CMP:  cmp_en = 1'b1;
			skse_pkg::PH_GRP:  grp_en = 1'b1;
			skse_pkg::PH_FIN:  fin = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

	assign cell_ctl = '{cmp_en: cmp_en, ins: fin && do_ins, del: fin && do_del};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= skse_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Hold the accepted command word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.command;
			key_q <= item.key[KEY_BITS-1:0];
		end
	end

	// Chain of cells
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		assign cell_valid[gi] = CNT_W'(gi) < fill_q;
		assign edge_vec[gi]   = lt_ext[gi] & ~cell_lt[gi];

		// the first cell sees a smaller key below it
		if (gi == 0) begin : g_lo_first
			assign key_lo[gi] = key_q;
			assign lt_ext[gi] = 1'b1;
		end else begin : g_lo_mid
			assign key_lo[gi] = cell_key[gi-1];
			assign lt_ext[gi] = cell_lt[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_hi_last
			assign key_hi[gi] = cell_key[gi];
		end else begin : g_hi_mid
			assign key_hi[gi] = cell_key[gi+1];
		end

		skse_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.valid  (cell_valid[gi]),
			.key_cmp(key_q),
			.lt_prev(lt_ext[gi]),
			.key_lo (key_lo[gi]),
			.key_hi (key_hi[gi]),
			.key    (cell_key[gi]),
			.lt     (cell_lt[gi]),
			.eq     (cell_eq[gi])
		);
	end

	// Group encoders over slices of the chain
	assign edge_pad = PAD_W'(edge_vec);
	assign eq_pad   = PAD_W'(cell_eq);

	for (genvar gg = 0; gg < GROUPS; gg++) begin : g_grp
		skse_grp_enc u_grp (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (grp_en),
			.edge_vec(edge_pad[gg*skse_pkg::GRP_SIZE +: skse_pkg::GRP_SIZE]),
			.eq_vec  (eq_pad[gg*skse_pkg::GRP_SIZE +: skse_pkg::GRP_SIZE]),
			.stat    (grp_stat[gg])
		);
	end

	// Combine group summaries into position and hit
	always_comb begin
		pos_grp  = '0;
		any_edge = 1'b0;
		hit_c    = 1'b0;
		for (int g = 0; g < GROUPS; g++) begin
			if (grp_stat[g].edge_hit) begin
				pos_grp = pos_grp | CNT_W'(g * skse_pkg::GRP_SIZE)
				        | CNT_W'(grp_stat[g].edge_idx);
			end
			any_edge = any_edge | grp_stat[g].edge_hit;
			hit_c    = hit_c | grp_stat[g].eq_hit;
		end
		// no edge means every cell holds a smaller key
		pos_c = any_edge ? pos_grp : CNT_W'(CAPACITY);
	end

	// Decide the outcome of the command
	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		status_c = skse_pkg::ST_FAIL;
		pos_out  = '0;
		fill_d   = fill_q;
		case (cmd_q)
			skse_pkg::CMD_ADD: begin
				if ((key_q != '0) && (fill_q != CNT_W'(CAPACITY)) && !hit_c) begin
					do_ins   = 1'b1;
					status_c = skse_pkg::ST_OK;
					pos_out  = pos_c;
					fill_d   = fill_q + CNT_W'(1);
				end
			end
			skse_pkg::CMD_REMOVE: begin
				pos_out = pos_c;
				if (hit_c) begin
					do_del   = 1'b1;
					status_c = skse_pkg::ST_OK;
					fill_d   = fill_q - CNT_W'(1);
				end else begin
					status_c = skse_pkg::ST_NOT_FOUND;
				end
			end
			skse_pkg::CMD_LOOKUP: begin
				if (key_q != '0) begin
					pos_out  = pos_c;
					status_c = hit_c ? skse_pkg::ST_OK : skse_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status_c = skse_pkg::ST_FAIL;
			end
		endcase
	end

	assign pos_ext  = EXT_W'(pos_out);
	assign fill_ext = EXT_W'(fill_d);

	// Update the fill count and capture the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
			if (fin) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.status      <= status_c;
			result_q.position    <= pos_ext[skse_pkg::FIELD_W-1:0];
			result_q.entry_count <= fill_ext[skse_pkg::FIELD_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
